[sv/wat_pkg.sv]
// Shared types, constants and the CORDIC angle table for the waypoint arrival tracker.
// No dependencies; wat_cordic, wat_isqrt and the top level import this package.
package wat_pkg;

    localparam int MAX_ENTRIES  = 64;
    localparam int CORDIC_STEPS = 16;
    localparam int ADDR_W       = $clog2(MAX_ENTRIES);
    localparam int CUR_W        = $clog2(MAX_ENTRIES + 1);
    localparam int LEN_W        = (CUR_W > 7) ? CUR_W : 7;
    localparam int STEP_W       = $clog2(CORDIC_STEPS + 1);
    localparam int VEC_W        = 34;   // CORDIC vector, holds gain growth of a Q2.28 pair
    localparam int SUM_W        = 52;   // sum of three squared 25 bit differences
    localparam int ROOT_W       = SUM_W / 2;
    localparam int MUL_W        = 25;
    localparam int PROD_W       = 2 * MUL_W;

    // configuration register indexes
    localparam logic [1:0] REG_POS_TOL = 2'd0;
    localparam logic [1:0] REG_YAW_TOL = 2'd1;
    localparam logic [1:0] REG_WP_CNT  = 2'd2;

    typedef enum logic [2:0] {
        OP_LOAD    = 3'd0,
        OP_POSE    = 3'd1,
        OP_REACH   = 3'd2,
        OP_SKIP    = 3'd3,
        OP_RETRY   = 3'd4,
        OP_RESTART = 3'd5
    } t_opcode;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        logic [15:0]        yaw;
    } t_entry;

    typedef struct packed {
        logic       reached;
        logic       skipped;
        logic [7:0] retry;
    } t_flag;

    typedef struct packed {
        logic signed [VEC_W-1:0] s;
        logic signed [VEC_W-1:0] c;
    } t_vec;

    // atan(2^-i) in 2^-32 turn units
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            default: v = 32'd81;
        endcase
        return v;
    endfunction

endpackage

[sv/wat_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module wat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[sv/wat_cordic.sv]
// Iterative CORDIC vectoring unit: atan2 of (s, c) as a 16 bit binary angle.
// Depends on wat_pkg (widths, step count, angle table).
module wat_cordic (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  wat_pkg::t_vec i_vec,
    output logic          o_done,
    output logic [15:0]   o_yaw
);
    import wat_pkg::*;

    logic                    r_busy, r_done, r_zero;
    logic [STEP_W-1:0]       r_cnt;
    logic signed [VEC_W-1:0] r_s, r_c, n_s, n_c;
    logic [31:0]             r_ang, n_ang, rounded;
    logic [31:0]             step_ang;

    always_comb begin
        step_ang = atan_turn(5'(r_cnt));
        if (!r_s[VEC_W-1]) begin
            n_c   = r_c + (r_s >>> r_cnt);
            n_s   = r_s - (r_c >>> r_cnt);
            n_ang = r_ang + step_ang;
        end else begin
            n_c   = r_c - (r_s >>> r_cnt);
            n_s   = r_s + (r_c >>> r_cnt);
            n_ang = r_ang - step_ang;
        end
        rounded = r_ang + 32'h0000_8000;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: pre-rotate by a quarter turn when c is negative
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_zero <= (i_vec.s == '0) && (i_vec.c == '0);
            if (i_vec.c[VEC_W-1] && !i_vec.s[VEC_W-1]) begin
                r_c   <= i_vec.s;
                r_s   <= -i_vec.c;
                r_ang <= 32'h4000_0000;
            end else if (i_vec.c[VEC_W-1]) begin
                r_c   <= -i_vec.s;
                r_s   <= i_vec.c;
                r_ang <= 32'hC000_0000;
            end else begin
                r_c   <= i_vec.c;
                r_s   <= i_vec.s;
                r_ang <= '0;
            end
        end else if (r_busy) begin
            r_c   <= n_c;
            r_s   <= n_s;
            r_ang <= n_ang;
        end
    end

    assign o_done = r_done;
    assign o_yaw  = r_zero ? 16'd0 : rounded[31:16];
endmodule

[sv/wat_isqrt.sv]
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on wat_pkg (SUM_W, ROOT_W).
module wat_isqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [wat_pkg::SUM_W-1:0]  i_value,
    output logic                       o_done,
    output logic [wat_pkg::ROOT_W-1:0] o_root
);
    import wat_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W + 1);
    localparam int REM_W = ROOT_W + 3;

    logic              r_busy, r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [SUM_W-1:0]  r_val;
    logic [REM_W-1:0]  r_rem, n_rem, trial;
    logic [ROOT_W-1:0] r_root;
    logic              fits;

    always_comb begin
        n_rem = {r_rem[REM_W-3:0], r_val[SUM_W-1 -: 2]};
        trial = {1'b0, r_root, 2'b01};
        fits  = (n_rem >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val  <= {r_val[SUM_W-3:0], 2'b00};
            r_rem  <= fits ? (n_rem - trial) : n_rem;
            r_root <= {r_root[ROOT_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

[sv/waypoint_arrival_tracker.sv]
// Top level of the waypoint arrival tracker: control sequencer, shared multiplier,
// entry and flag memories. Depends on wat_pkg, wat_ram, wat_cordic and wat_isqrt.
//
// channel   direction  handshake                    payload
// command   in         i_start, transfer if !o_busy i_opcode .. i_quat_w
// result    out        o_done strobe, one cycle     o_current_slot .. o_skipped_total
// config    in         i_cfg_we, no wait            i_cfg_idx, i_cfg_data
//
// Steps from the accepting edge to the edge that takes the result: load goes through
// multiply, CORDIC, write-back, status read, output and strobe; pose check through
// multiply, CORDIC and square root, then the same four; mark, skip, retry, restart and
// unused opcodes go straight to those four. o_busy is high from the transfer until the
// strobe cycle, which may take the next transfer.
// Reset clears cursor, counters and flag valid bits at once; no clearing pass.
// The receiver cannot stall: the result strobe lasts exactly one cycle.
module waypoint_arrival_tracker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_opcode,
    input  logic [5:0]  i_entry_index,
    input  logic signed [23:0] i_pos_x,
    input  logic signed [23:0] i_pos_y,
    input  logic signed [23:0] i_pos_z,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    input  logic signed [15:0] i_quat_w,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output logic        o_done,
    output logic [6:0]  o_current_slot,
    output logic        o_route_done,
    output logic        o_pose_reached,
    output logic [24:0] o_distance_mm,
    output logic signed [15:0] o_yaw_error,
    output logic [7:0]  o_retry_total,
    output logic [6:0]  o_reached_total,
    output logic [6:0]  o_skipped_total
);
    import wat_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_CORD = 7'b0000100,
        S_SQRT = 7'b0001000,
        S_WB   = 7'b0010000,
        S_ST1  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_state;

    // configuration
    logic [15:0] r_pos_tol, r_yaw_tol;
    logic [6:0]  r_wp_cnt;

    // latched command
    t_opcode            r_op;
    logic [5:0]         r_slot;
    logic signed [23:0] r_px, r_py, r_pz;
    logic signed [15:0] r_qx, r_qy, r_qz, r_qw;
    logic               r_active;

    // route state
    logic [CUR_W-1:0]       r_cursor;
    logic [6:0]             r_reach_cnt, r_skip_cnt;
    logic [MAX_ENTRIES-1:0] r_fvalid;
    logic                   r_rd_fv;

    // multiply sequencer
    logic [3:0]               r_mcnt;
    logic [2:0]               r_pidx;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [VEC_W-1:0]  r_sacc, r_cacc;
    logic [SUM_W-1:0]         r_sum;
    logic [31:0]              r_tol2;
    logic [3:0]               mul_last;

    // units and results
    logic        r_cord_go, r_sq_go;
    logic        cord_done, sq_done;
    logic [15:0] cord_yaw, r_yaw;
    logic [ROOT_W-1:0] sq_root;
    t_vec        cord_vec;
    logic        r_done, r_hit;
    logic [24:0] r_dist;
    logic [15:0] r_yerr;
    logic [6:0]  r_o_slot;
    logic        r_o_rdone;
    logic [7:0]  r_o_retry;

    // memories
    t_entry            ent_rd, ent_wr;
    t_flag             flg_rd, flg_wr, flg_cur;
    logic              ent_we, flg_we;
    logic [ADDR_W-1:0] cur_idx;

    logic [LEN_W-1:0] route_len;
    logic             active_now;
    logic             accept;

    logic signed [MUL_W-1:0] dx, dy, dz;
    logic [15:0] yerr;
    logic [16:0] ymag;

    assign accept  = i_start && (r_state == S_IDLE);
    assign cur_idx = r_cursor[ADDR_W-1:0];

    assign route_len  = (LEN_W'(r_wp_cnt) > LEN_W'(MAX_ENTRIES)) ?
                        LEN_W'(MAX_ENTRIES) : LEN_W'(r_wp_cnt);
    assign active_now = (LEN_W'(r_cursor) < route_len);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_tol <= 16'd100;
            r_yaw_tol <= 16'd1820;
            r_wp_cnt  <= 7'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_POS_TOL: r_pos_tol <= i_cfg_data;
                REG_YAW_TOL: r_yaw_tol <= i_cfg_data;
                REG_WP_CNT:  r_wp_cnt  <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    wat_ram #(.WIDTH($bits(t_entry)), .DEPTH(MAX_ENTRIES)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (r_slot[ADDR_W-1:0]),
        .i_wdata (ent_wr),
        .i_raddr (cur_idx),
        .o_rdata (ent_rd)
    );

    wat_ram #(.WIDTH($bits(t_flag)), .DEPTH(MAX_ENTRIES)) u_flag_ram (
        .i_clk   (i_clk),
        .i_we    (flg_we),
        .i_waddr (cur_idx),
        .i_wdata (flg_wr),
        .i_raddr (cur_idx),
        .o_rdata (flg_rd)
    );

    // valid bit read lines up with the registered RAM read
    always_ff @(posedge i_clk) begin
        r_rd_fv <= r_fvalid[cur_idx];
    end

    assign flg_cur = r_rd_fv ? flg_rd : '0;

    // differences against the current waypoint (stable while an item runs)
    assign dx = MUL_W'(r_px) - MUL_W'(ent_rd.x);
    assign dy = MUL_W'(r_py) - MUL_W'(ent_rd.y);
    assign dz = MUL_W'(r_pz) - MUL_W'(ent_rd.z);

    assign mul_last = (r_op == OP_POSE) ? 4'd8 : 4'd4;

    always_comb begin
        case (r_mcnt[2:0])
            3'd0:    begin mul_a = MUL_W'(r_qw); mul_b = MUL_W'(r_qz); end
            3'd1:    begin mul_a = MUL_W'(r_qx); mul_b = MUL_W'(r_qy); end
            3'd2:    begin mul_a = MUL_W'(r_qy); mul_b = MUL_W'(r_qy); end
            3'd3:    begin mul_a = MUL_W'(r_qz); mul_b = MUL_W'(r_qz); end
            3'd4:    begin mul_a = dx; mul_b = dx; end
            3'd5:    begin mul_a = dy; mul_b = dy; end
            3'd6:    begin mul_a = dz; mul_b = dz; end
            default: begin
                mul_a = MUL_W'({1'b0, r_pos_tol});
                mul_b = MUL_W'({1'b0, r_pos_tol});
            end
        endcase
    end

    assign cord_vec.s = r_sacc <<< 1;
    assign cord_vec.c = (VEC_W'(1) <<< 28) - (r_cacc <<< 1);

    wat_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cord_go),
        .i_vec   (cord_vec),
        .o_done  (cord_done),
        .o_yaw   (cord_yaw)
    );

    wat_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sq_go),
        .i_value (r_sum),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // yaw error wraps; half a turn has magnitude 32768
    assign yerr = r_yaw - ent_rd.yaw;
    assign ymag = yerr[15] ? (17'h10000 - {1'b0, yerr}) : {1'b0, yerr};

    // entry write on load
    assign ent_we     = (r_state == S_WB) && (r_op == OP_LOAD);
    assign ent_wr.x   = r_px;
    assign ent_wr.y   = r_py;
    assign ent_wr.z   = r_pz;
    assign ent_wr.yaw = r_yaw;

    // flag read-modify-write for mark, skip and retry
    always_comb begin
        flg_wr = flg_cur;
        flg_we = 1'b0;
        if ((r_state == S_WB) && r_active) begin
            case (r_op)
                OP_REACH: begin flg_wr.reached = 1'b1; flg_we = 1'b1; end
                OP_SKIP:  begin flg_wr.skipped = 1'b1; flg_we = 1'b1; end
                OP_RETRY: begin
                    if (flg_cur.retry != 8'hFF) begin
                        flg_wr.retry = flg_cur.retry + 8'd1;
                    end
                    flg_we = 1'b1;
                end
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cursor    <= '0;
            r_reach_cnt <= '0;
            r_skip_cnt  <= '0;
            r_fvalid    <= '0;
            r_done      <= 1'b0;
            r_cord_go   <= 1'b0;
            r_sq_go     <= 1'b0;
            r_mcnt      <= '0;
        end else begin
            r_done    <= 1'b0;
            r_cord_go <= 1'b0;
            r_sq_go   <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_mcnt <= '0;
                        if ((t_opcode'(i_opcode) == OP_LOAD) ||
                            (t_opcode'(i_opcode) == OP_POSE)) begin
                            r_state <= S_MUL;
                        end else begin
                            r_state <= S_WB;
                        end
                    end
                end
                S_MUL: begin
                    r_mcnt <= r_mcnt + 4'd1;
                    if (r_mcnt == mul_last) begin
                        r_cord_go <= 1'b1;
                        r_state   <= S_CORD;
                    end
                end
                S_CORD: begin
                    if (cord_done) begin
                        if (r_op == OP_POSE) begin
                            r_sq_go <= 1'b1;
                            r_state <= S_SQRT;
                        end else begin
                            r_state <= S_WB;
                        end
                    end
                end
                S_SQRT: begin
                    if (sq_done) begin
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    // on mark or skip, advance the cursor, count newly set flags, saturate at 127
                    if (r_active && ((r_op == OP_REACH) || (r_op == OP_SKIP))) begin
                        r_cursor          <= r_cursor + 1'b1;
                        r_fvalid[cur_idx] <= 1'b1;
                        if ((r_op == OP_REACH) && !flg_cur.reached &&
                            (r_reach_cnt != 7'd127)) begin
                            r_reach_cnt <= r_reach_cnt + 7'd1;
                        end
                        if ((r_op == OP_SKIP) && !flg_cur.skipped &&
                            (r_skip_cnt != 7'd127)) begin
                            r_skip_cnt <= r_skip_cnt + 7'd1;
                        end
                    end
                    if (r_active && (r_op == OP_RETRY)) begin
                        r_fvalid[cur_idx] <= 1'b1;
                    end
                    if (r_op == OP_RESTART) begin
                        r_cursor    <= '0;
                        r_reach_cnt <= '0;
                        r_skip_cnt  <= '0;
                        r_fvalid    <= '0;
                    end
                    r_state <= S_ST1;
                end
                S_ST1: begin
                    // status read of the new cursor is in flight
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= t_opcode'(i_opcode);
            r_slot   <= i_entry_index;
            r_px     <= i_pos_x;
            r_py     <= i_pos_y;
            r_pz     <= i_pos_z;
            r_qx     <= i_quat_x;
            r_qy     <= i_quat_y;
            r_qz     <= i_quat_z;
            r_qw     <= i_quat_w;
            r_active <= active_now;
            r_sacc   <= '0;
            r_cacc   <= '0;
            r_sum    <= '0;
            r_tol2   <= '0;
            r_hit    <= 1'b0;
            r_dist   <= '0;
            r_yerr   <= '0;
        end
        if (r_state == S_MUL) begin
            r_prod <= mul_a * mul_b;
            r_pidx <= r_mcnt[2:0];
            // accumulate the product of the previous cycle
            if (r_mcnt != 4'd0) begin
                case (r_pidx) inside
                    [3'd0:3'd1]: r_sacc <= r_sacc + VEC_W'(r_prod);
                    [3'd2:3'd3]: r_cacc <= r_cacc + VEC_W'(r_prod);
                    [3'd4:3'd6]: r_sum  <= r_sum + SUM_W'(unsigned'(r_prod));
                    default:     r_tol2 <= 32'(unsigned'(r_prod));
                endcase
            end
        end
        if ((r_state == S_CORD) && cord_done) begin
            r_yaw <= cord_yaw;
        end
        if ((r_state == S_SQRT) && sq_done && r_active) begin
            r_dist <= 25'(sq_root);
            r_yerr <= yerr;
            r_hit  <= (r_sum < SUM_W'(r_tol2)) && (ymag < {1'b0, r_yaw_tol});
        end
        if (r_state == S_OUT) begin
            r_o_slot  <= 7'(r_cursor);
            r_o_rdone <= !active_now;
            r_o_retry <= active_now ? flg_cur.retry : 8'd0;
        end
    end

    assign o_busy          = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_current_slot  = r_o_slot;
    assign o_route_done    = r_o_rdone;
    assign o_pose_reached  = r_hit;
    assign o_distance_mm   = r_dist;
    assign o_yaw_error     = r_yerr;
    assign o_retry_total   = r_o_retry;
    assign o_reached_total = r_reach_cnt;
    assign o_skipped_total = r_skip_cnt;

    // the result strobe only follows the output state
    a_done_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state == S_OUT))
        else $error("result strobe without output state");

    // the cursor never runs past the table
    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LEN_W'(r_cursor) <= LEN_W'(MAX_ENTRIES))
        else $error("cursor beyond table");

    // a transfer makes the block busy from the accepting edge on
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_busy)
        else $error("transfer did not raise busy");

    // no memory write outside the write-back state
    a_write_in_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ent_we || flg_we) |-> (r_state == S_WB))
        else $error("memory write outside write-back");
endmodule
